FILE: design/nps_pkg.sv
// Shared types and constants for the nearest point search unit.
// Has no dependencies. The controller, the datapath and the top level import it.
package nps_pkg;

    // Field widths at the ports
    localparam int IDX_W   = 10;
    localparam int CNT_W   = 11;
    localparam int FIELD_W = 16;
    localparam int DIST_W  = 36;

    // Default parameter values
    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_COORD_BITS = 16;

    // Request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic write_pt;    // store the incoming point
        logic load_query;  // latch query point and scan length, restart scan
        logic scan;        // read the next store entry into the pipe
        logic load_out;    // move the result into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic cnt_zero;    // configured scan length is zero
        logic last_addr;   // entry being read now is the last one
        logic pipe_busy;   // distance pipe still holds entries
    } t_dp_sts;

endpackage

FILE: design/nearest_point_search_unit.sv
// Top level of the nearest point search unit: brute-force 3D nearest neighbor.
// Instantiates nps_ctrl and nps_dp; uses nps_pkg for widths and defaults.
//
// Usage
//   Input channel (i_in_valid / o_in_stall): each transaction is a write
//   (req_type 0: store x/y/z at point_index, no result) or a query
//   (req_type 1: scan entries 0..point_count-1, one result).
//   Output channel (o_out_valid / i_out_stall): found, nearest_index and
//   squared distance; the lowest index wins on a tie.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): point_count.
//   Write it only while the unit is idle.
// Timing
//   A write is stored when accepted and leaves the unit idle. A query with n
//   entries (n clamped to MAX_POINTS) ends with its result in the output
//   register, and the next transaction can be taken in the same cycle that the
//   result appears. The cost is set by the single read port of the point store,
//   one entry per cycle, followed by a diff/square/sum/compare pipe. An empty
//   query skips the scan and the pipe. A result waits in the output register
//   under i_out_stall; a finished query holds off new input until it frees up.
// Reset
//   Synchronous, active low. Clears control and point_count; store contents
//   are undefined until written.
module nearest_point_search_unit
    import nps_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // query / load transactions
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_req_type,
    input  logic [IDX_W-1:0]          i_point_index,
    input  logic signed [FIELD_W-1:0] i_x_coord,
    input  logic signed [FIELD_W-1:0] i_y_coord,
    input  logic signed [FIELD_W-1:0] i_z_coord,
    // results
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_found,
    output logic [IDX_W-1:0]          o_nearest_index,
    output logic [DIST_W-1:0]         o_nearest_dist_sq,
    // point_count register
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CNT_W-1:0]          i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Register writes are always taken.
    assign o_cfg_ready = 1'b1;

    nps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    nps_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_point_index     (i_point_index),
        .i_x_coord         (i_x_coord),
        .i_y_coord         (i_y_coord),
        .i_z_coord         (i_z_coord),
        .o_found           (o_found),
        .o_nearest_index   (o_nearest_index),
        .o_nearest_dist_sq (o_nearest_dist_sq)
    );

endmodule

FILE: design/nps_ctrl.sv
// Sequencer for the nearest point search unit: handshakes and scan control.
// Uses nps_pkg for the command and status structs and request codes.
module nps_ctrl
    import nps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_req_type,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_acc;
    logic   out_free;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_req_type == REQ_WRITE) begin
                        o_cmd.write_pt = 1'b1;
                    end else begin
                        o_cmd.load_query = 1'b1;
                        n_state = i_sts.cnt_zero ? S_FINISH : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.last_addr) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: design/nps_dp.sv
// Datapath of the nearest point search unit: point store, distance pipe,
// running minimum, scan-length register and result register. Uses nps_pkg.
module nps_dp
    import nps_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    output t_dp_sts                   o_sts,
    input  logic                      i_cfg_we,
    input  logic [CNT_W-1:0]          i_cfg_data,
    input  logic [IDX_W-1:0]          i_point_index,
    input  logic signed [FIELD_W-1:0] i_x_coord,
    input  logic signed [FIELD_W-1:0] i_y_coord,
    input  logic signed [FIELD_W-1:0] i_z_coord,
    output logic                      o_found,
    output logic [IDX_W-1:0]          o_nearest_index,
    output logic [DIST_W-1:0]         o_nearest_dist_sq
);

    localparam int CB = COORD_BITS;
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int SW = 2 * CB + 2;      // one squared difference
    localparam int DW = 2 * CB + 4;      // sum of three
    localparam logic [63:0] DIST_MAX = (64'd1 << DIST_W) - 64'd1;

    // Configuration
    logic [CNT_W-1:0] r_point_count;

    // Store
    logic [3*CB-1:0] r_mem [MAX_POINTS];
    logic [AW-1:0]   wr_addr;
    logic            wr_in_range;
    logic signed [CB-1:0] cx, cy, cz;

    // Query and scan
    logic signed [CB-1:0] r_qx, r_qy, r_qz;
    logic [NW-1:0]        r_n, n_eff;
    logic [AW-1:0]        r_addr;

    // Pipe
    logic                 r_v1, r_v2, r_v3, r_v4;
    logic [AW-1:0]        r_i1, r_i2, r_i3, r_i4;
    logic [3*CB-1:0]      r_rdata;
    logic signed [CB-1:0] px, py, pz;
    logic signed [CB:0]   r_dx, r_dy, r_dz;
    logic signed [SW-1:0] prod_x, prod_y, prod_z;
    logic [SW-1:0]        r_sqx, r_sqy, r_sqz;
    logic [DW-1:0]        r_sum;

    // Running minimum
    logic          r_first;
    logic [DW-1:0] r_best;
    logic [AW-1:0] r_best_i;
    logic [63:0]   best_wide;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (i_cfg_we) begin
            r_point_count <= i_cfg_data;
        end
    end

    // Coordinates are sign-extended or cut to the stored width.
    assign cx = CB'(i_x_coord);
    assign cy = CB'(i_y_coord);
    assign cz = CB'(i_z_coord);

    assign wr_in_range = (32'(i_point_index) < 32'(MAX_POINTS));
    assign wr_addr     = AW'(i_point_index);

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_pt && wr_in_range) begin
            r_mem[wr_addr] <= {cx, cy, cz};
        end
        if (i_cmd.scan) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    // Scan length clamps at the store depth.
    assign n_eff = (32'(r_point_count) > 32'(MAX_POINTS)) ? NW'(MAX_POINTS)
                                                          : NW'(r_point_count);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_qx <= cx;
            r_qy <= cy;
            r_qz <= cz;
            r_n  <= n_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.load_query) begin
            r_addr <= '0;
        end else if (i_cmd.scan) begin
            r_addr <= r_addr + AW'(1);
        end
    end

    assign {px, py, pz} = r_rdata;
    assign prod_x = r_dx * r_dx;
    assign prod_y = r_dy * r_dy;
    assign prod_z = r_dz * r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1  <= r_addr;
        r_i2  <= r_i1;
        r_i3  <= r_i2;
        r_i4  <= r_i3;
        r_dx  <= (CB + 1)'(r_qx) - (CB + 1)'(px);
        r_dy  <= (CB + 1)'(r_qy) - (CB + 1)'(py);
        r_dz  <= (CB + 1)'(r_qz) - (CB + 1)'(pz);
        r_sqx <= unsigned'(prod_x);
        r_sqy <= unsigned'(prod_y);
        r_sqz <= unsigned'(prod_z);
        r_sum <= DW'(r_sqx) + DW'(r_sqy) + DW'(r_sqz);
    end

    // Strict less-than keeps the lowest index on a tie.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_first <= 1'b1;
        end else if (r_v4 && (r_first || (r_sum < r_best))) begin
            r_first  <= 1'b0;
            r_best   <= r_sum;
            r_best_i <= r_i4;
        end
    end

    assign best_wide = 64'(r_best);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_n == '0) begin
                o_found           <= 1'b0;
                o_nearest_index   <= '0;
                o_nearest_dist_sq <= '0;
            end else begin
                o_found           <= 1'b1;
                o_nearest_index   <= IDX_W'(r_best_i);
                o_nearest_dist_sq <= (best_wide > DIST_MAX) ? DIST_W'(DIST_MAX)
                                                            : DIST_W'(best_wide);
            end
        end
    end

    assign o_sts.cnt_zero  = (n_eff == '0);
    assign o_sts.last_addr = ((32'(r_addr) + 32'd1) == 32'(r_n));
    assign o_sts.pipe_busy = r_v1 || r_v2 || r_v3 || r_v4;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for nearest_point_search_unit: load and query transactions,
// point_count writes between phases. Depends on nps_pkg and the unit's RTL only.
module testbench;
    import nps_pkg::*;

    localparam int     MAX_PTS       = DEF_MAX_POINTS;
    localparam int     FILL_COUNT    = 256;      // store entries loaded before the random phases
    localparam int     CYCLE_LIMIT   = 1000000;  // watchdog bound for the whole run
    localparam int     SETTLE_CYCLES = 40;       // margin for stray results after the queues drain
    localparam int     RANDOM_PHASES = 16;
    localparam int     PALETTE_SIZE  = 8;
    localparam longint DIST_CAP      = (longint'(1) << DIST_W) - 1;

    typedef logic signed [FIELD_W-1:0] t_coord;

    localparam t_coord COORD_MIN = -32768;
    localparam t_coord COORD_MAX = 32767;

    // one input transaction
    typedef struct {
        logic             req_type;
        logic [IDX_W-1:0] point_index;
        t_coord           x;
        t_coord           y;
        t_coord           z;
    } t_request;

    // one result transaction
    typedef struct {
        logic              found;
        logic [IDX_W-1:0]  nearest_index;
        logic [DIST_W-1:0] dist_sq;
    } t_nearest;

    // ---------------------------------------------------------------- DUT ports
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              in_valid    = 1'b0;
    logic              req_type    = REQ_WRITE;
    logic [IDX_W-1:0]  point_index = '0;
    t_coord            x_coord     = '0;
    t_coord            y_coord     = '0;
    t_coord            z_coord     = '0;
    logic              out_stall   = 1'b0;
    logic              cfg_valid   = 1'b0;
    logic [CNT_W-1:0]  cfg_data    = '0;

    logic              o_in_stall;
    logic              o_out_valid;
    logic              o_found;
    logic [IDX_W-1:0]  o_nearest_index;
    logic [DIST_W-1:0] o_nearest_dist_sq;
    logic              o_cfg_ready;

    nearest_point_search_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (req_type),
        .i_point_index     (point_index),
        .i_x_coord         (x_coord),
        .i_y_coord         (y_coord),
        .i_z_coord         (z_coord),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .o_found           (o_found),
        .o_nearest_index   (o_nearest_index),
        .o_nearest_dist_sq (o_nearest_dist_sq),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (cfg_data)
    );

    // ---------------------------------------------------------------- TB state
    t_request request_backlog[$];   // filled by the sequence, drained by the driver
    t_nearest nearest_due[$];       // predicted results, oldest first
    t_request held;                 // transaction currently on the input port
    t_nearest due_result;

    // mirror of the point store and of point_count, updated on acceptance
    t_coord           mirror_x [MAX_PTS];
    t_coord           mirror_y [MAX_PTS];
    t_coord           mirror_z [MAX_PTS];
    logic [CNT_W-1:0] scan_count = '0;

    // a few shared points so that stored duplicates produce distance ties
    t_coord palette_x [PALETTE_SIZE];
    t_coord palette_y [PALETTE_SIZE];
    t_coord palette_z [PALETTE_SIZE];

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;

    // ---------------------------------------------------------------- predictor
    // Exact brute-force scan over the mirror; strict less-than keeps the
    // lowest index on a tie. Scan length clamps at the store depth.
    function automatic t_nearest find_nearest(t_coord qx, t_coord qy, t_coord qz);
        t_nearest r;
        int       n;
        int       i;
        longint   dx, dy, dz, d, best;
        n = (scan_count > MAX_PTS) ? MAX_PTS : int'(scan_count);
        r.found         = 1'b0;
        r.nearest_index = '0;
        r.dist_sq       = '0;
        best            = 0;
        for (i = 0; i < n; i++) begin
            dx = longint'(qx) - longint'(mirror_x[i]);
            dy = longint'(qy) - longint'(mirror_y[i]);
            dz = longint'(qz) - longint'(mirror_z[i]);
            d  = dx * dx + dy * dy + dz * dz;
            if (i == 0 || d < best) begin
                best            = d;
                r.nearest_index = IDX_W'(i);
            end
        end
        if (n > 0) begin
            r.found   = 1'b1;
            r.dist_sq = (best > DIST_CAP) ? DIST_CAP[DIST_W-1:0] : best[DIST_W-1:0];
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- clock, watchdog
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("nearest_point_search_unit regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- driver
    // Accepts on valid && !stall. The mirror and the result queue are updated
    // at the accepting edge, so config and store state match what the unit saw.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                if (held.req_type == REQ_WRITE) begin
                    mirror_x[held.point_index] = held.x;
                    mirror_y[held.point_index] = held.y;
                    mirror_z[held.point_index] = held.z;
                end else begin
                    nearest_due.insert(nearest_due.size(),
                                       find_nearest(held.x, held.y, held.z));
                end
            end
            // payload only moves once the port is free; held stays put under stall
            if (!in_valid || !o_in_stall) begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    held = request_backlog.pop_front();
                    in_valid    <= 1'b1;
                    req_type    <= held.req_type;
                    point_index <= held.point_index;
                    x_coord     <= held.x;
                    y_coord     <= held.y;
                    z_coord     <= held.z;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (nearest_due.size() == 0) begin
                    $error("unexpected result: found=%0d nearest_index=%0d nearest_dist_sq=%0d",
                           o_found, o_nearest_index, o_nearest_dist_sq);
                    mismatch_count++;
                end else begin
                    due_result = nearest_due.pop_front();
                    if (o_found !== due_result.found) begin
                        $error("found: expected %0d, got %0d", due_result.found, o_found);
                        mismatch_count++;
                    end
                    if (o_nearest_index !== due_result.nearest_index) begin
                        $error("nearest_index: expected %0d, got %0d",
                               due_result.nearest_index, o_nearest_index);
                        mismatch_count++;
                    end
                    if (o_nearest_dist_sq !== due_result.dist_sq) begin
                        $error("nearest_dist_sq: expected %0d, got %0d",
                               due_result.dist_sq, o_nearest_dist_sq);
                        mismatch_count++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ---------------------------------------------------------------- sequence helpers
    // Wait until every queued transaction is taken and every result is back,
    // then leave the unit idle for a settling margin. Ends on a rising edge.
    task automatic settle();
        while (request_backlog.size() != 0 || in_valid || nearest_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // point_count changes only with the unit idle; returns on a falling edge
    task automatic write_point_count(input logic [CNT_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        scan_count = value;
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic void add_write(logic [IDX_W-1:0] idx, t_coord x, t_coord y, t_coord z);
        t_request r;
        r.req_type    = REQ_WRITE;
        r.point_index = idx;
        r.x           = x;
        r.y           = y;
        r.z           = z;
        request_backlog.insert(request_backlog.size(), r);
    endfunction

    // point_index is don't-care for a query: send noise there
    function automatic void add_query(t_coord x, t_coord y, t_coord z);
        t_request r;
        r.req_type    = REQ_QUERY;
        r.point_index = IDX_W'($urandom);
        r.x           = x;
        r.y           = y;
        r.z           = z;
        request_backlog.insert(request_backlog.size(), r);
    endfunction

    // full range (toggles every bit), the two extremes, or near the origin
    function automatic t_coord pick_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return t_coord'($urandom);
        if (sel == 3)
            return COORD_MIN;
        if (sel == 4)
            return COORD_MAX;
        return t_coord'(int'($urandom_range(0, 1023)) - 512);
    endfunction

    // Writes land mostly inside the scanned range so they change answers;
    // queries often sit on or next to a palette point that several entries share.
    function automatic void add_random_item(int span);
        int               p;
        int               lim;
        logic [IDX_W-1:0] idx;
        p   = $urandom_range(0, PALETTE_SIZE - 1);
        lim = (span > MAX_PTS) ? MAX_PTS : span;
        if ($urandom_range(0, 99) < 45) begin
            if (lim > 0 && $urandom_range(0, 3) != 0)
                idx = IDX_W'($urandom_range(0, lim - 1));
            else
                idx = IDX_W'($urandom);
            if ($urandom_range(0, 99) < 35)
                add_write(idx, palette_x[p], palette_y[p], palette_z[p]);
            else
                add_write(idx, pick_coord(), pick_coord(), pick_coord());
        end else if ($urandom_range(0, 99) < 40) begin
            add_query(t_coord'(int'(palette_x[p]) + int'($urandom_range(0, 6)) - 3),
                      t_coord'(int'(palette_y[p]) + int'($urandom_range(0, 6)) - 3),
                      t_coord'(int'(palette_z[p]) + int'($urandom_range(0, 6)) - 3));
        end else begin
            add_query(pick_coord(), pick_coord(), pick_coord());
        end
    endfunction

    // ---------------------------------------------------------------- sequence
    initial begin
        int span;
        int items;
        int ph;
        int k;

        for (k = 0; k < PALETTE_SIZE; k++) begin
            palette_x[k] = pick_coord();
            palette_y[k] = pick_coord();
            palette_z[k] = pick_coord();
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // point_count is 0 out of reset: empty scans, store loads
        add_query(COORD_MIN, COORD_MAX, 0);
        add_write(0, COORD_MIN, COORD_MIN, COORD_MIN);
        add_write(1, 100, 0, 0);
        add_write(2, -100, 0, 0);
        add_write(3, COORD_MAX, COORD_MAX, COORD_MAX);
        add_write(IDX_W'(MAX_PTS - 1), COORD_MAX, COORD_MIN, -1);
        add_query(0, 0, 0);

        // single entry, opposite corner: largest possible distance
        write_point_count(1);
        add_query(COORD_MAX, COORD_MAX, COORD_MAX);

        // ties between entries 1 and 2, exact hits on the corners
        write_point_count(4);
        add_query(0, 0, 0);
        add_query(COORD_MIN, COORD_MIN, COORD_MIN);
        add_query(COORD_MAX, COORD_MAX, COORD_MAX);
        add_query(1, -1, 0);
        add_write(2, 100, 0, 0);
        add_query(100, 0, 0);

        // explicit zero count
        write_point_count(0);
        add_query(COORD_MAX, COORD_MIN, 0);

        // load the low part of the store; every later scan stays inside it
        sender_idle_pct = 71;
        for (k = 0; k < FILL_COUNT; k++) begin
            if ($urandom_range(0, 3) == 0)
                add_write(IDX_W'(k), palette_x[k % PALETTE_SIZE], palette_y[k % PALETTE_SIZE],
                          palette_z[k % PALETTE_SIZE]);
            else
                add_write(IDX_W'(k), pick_coord(), pick_coord(), pick_coord());
        end

        // longest scan over the loaded entries
        write_point_count(CNT_W'(FILL_COUNT));
        sender_idle_pct = 0;
        add_query(pick_coord(), pick_coord(), pick_coord());
        add_query(palette_x[0], palette_y[0], palette_z[0]);
        add_query(pick_coord(), pick_coord(), pick_coord());
        add_query(COORD_MIN, COORD_MAX, COORD_MIN);

        // random phases: mostly short scans, two with long scans
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph % 8 == 5) begin
                span  = (ph == 5) ? FILL_COUNT : $urandom_range(FILL_COUNT / 2, FILL_COUNT);
                items = 5;
            end else begin
                span  = $urandom_range(0, 40);
                items = 21;
            end
            write_point_count(CNT_W'(span));
            case (ph % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 71; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 71; end
                default: begin sender_idle_pct = 22; stall_pct = 22; end
            endcase
            repeat (items) add_random_item(span);
        end

        settle();
        if (mismatch_count == 0 && nearest_due.size() == 0)
            $display("nearest_point_search_unit regression: pass");
        else
            $display("nearest_point_search_unit regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
design/nps_pkg.sv
design/nps_ctrl.sv
design/nps_dp.sv
design/nearest_point_search_unit.sv
sim/testbench.sv
